### hdl/aqfc_pkg.sv
// Shared types, codes and reset constants for the air quality fan controller.
// Used by aqfc_cfg, aqfc_grade and air_quality_fan_controller; no dependencies.
`timescale 1ns / 1ps

package aqfc_pkg;

    localparam int unsigned LimitWidth = 16;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned MsWidth    = 10;
    localparam int unsigned CfgAddrW   = 3;

    // Millisecond ticks per heartbeat second (1 .. 1023)
    localparam logic [MsWidth-1:0] TicksPerSecond = MsWidth'(1000);

    localparam logic [LimitWidth-1:0] Pm25GoodReset = 16'd15;
    localparam logic [LimitWidth-1:0] Pm25MidReset  = 16'd35;
    localparam logic [LimitWidth-1:0] Pm25BadReset  = 16'd75;
    localparam logic [LimitWidth-1:0] Pm10GoodReset = 16'd30;
    localparam logic [LimitWidth-1:0] Pm10MidReset  = 16'd80;
    localparam logic [LimitWidth-1:0] Pm10BadReset  = 16'd150;
    localparam logic [CountWidth-1:0] FanDelayReset = 8'd60;
    localparam logic [CountWidth-1:0] HoldReset     = 8'd100;

    typedef enum logic [CfgAddrW-1:0] {
        REG_PM25_GOOD = 3'd0,
        REG_PM25_MID  = 3'd1,
        REG_PM25_BAD  = 3'd2,
        REG_PM10_GOOD = 3'd3,
        REG_PM10_MID  = 3'd4,
        REG_PM10_BAD  = 3'd5,
        REG_FAN_DELAY = 3'd6,
        REG_SW_HOLD   = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        REQ_SWITCH  = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_READING = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_AUTO   = 2'd2
    } fan_mode_t;

    typedef enum logic [1:0] {
        GRADE_GOOD  = 2'd0,
        GRADE_MID   = 2'd1,
        GRADE_BAD   = 2'd2,
        GRADE_ERROR = 2'd3
    } grade_t;

    // LED bit order: red, yellow, green
    localparam logic [2:0] LedRed    = 3'b100;
    localparam logic [2:0] LedYellow = 3'b010;
    localparam logic [2:0] LedGreen  = 3'b001;

    typedef struct packed {
        logic [LimitWidth-1:0] pm25_good_limit;
        logic [LimitWidth-1:0] pm25_mid_limit;
        logic [LimitWidth-1:0] pm25_bad_limit;
        logic [LimitWidth-1:0] pm10_good_limit;
        logic [LimitWidth-1:0] pm10_mid_limit;
        logic [LimitWidth-1:0] pm10_bad_limit;
        logic [CountWidth-1:0] fan_delay_seconds;
        logic [CountWidth-1:0] switch_hold_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic                  sw1_pressed;
        logic                  sw2_pressed;
        logic [LimitWidth-1:0] pm25_value;
        logic [LimitWidth-1:0] pm10_value;
    } in_word_t;

    typedef struct packed {
        logic       fan_on;
        logic [1:0] air_grade;
        logic       led_red;
        logic       led_yel;
        logic       led_grn;
        logic [1:0] fan_mode;
        logic       heartbeat_led;
    } out_word_t;

    function automatic logic [2:0] grade_leds(input grade_t grade);
        logic [2:0] leds;
        case (grade)
            GRADE_GOOD: leds = LedGreen;
            GRADE_MID:  leds = LedYellow;
            GRADE_BAD:  leds = LedRed;
            default:    leds = LedRed | LedYellow | LedGreen;
        endcase
        return leds;
    endfunction

endpackage

### hdl/aqfc_cfg.sv
// Configuration register file: thresholds, fan delay and switch hold count.
// Depends on aqfc_pkg.
`timescale 1ns / 1ps

module aqfc_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [aqfc_pkg::CfgAddrW-1:0]     cfg_addr,
    input  logic [aqfc_pkg::LimitWidth-1:0]   cfg_wdata,
    output aqfc_pkg::cfg_t                    cfg
);

    aqfc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pm25_good_limit   <= aqfc_pkg::Pm25GoodReset;
            cfg_reg.pm25_mid_limit    <= aqfc_pkg::Pm25MidReset;
            cfg_reg.pm25_bad_limit    <= aqfc_pkg::Pm25BadReset;
            cfg_reg.pm10_good_limit   <= aqfc_pkg::Pm10GoodReset;
            cfg_reg.pm10_mid_limit    <= aqfc_pkg::Pm10MidReset;
            cfg_reg.pm10_bad_limit    <= aqfc_pkg::Pm10BadReset;
            cfg_reg.fan_delay_seconds <= aqfc_pkg::FanDelayReset;
            cfg_reg.switch_hold_count <= aqfc_pkg::HoldReset;
        end else if (cfg_we) begin
            case (aqfc_pkg::reg_index_t'(cfg_addr))
                aqfc_pkg::REG_PM25_GOOD: cfg_reg.pm25_good_limit <= cfg_wdata;
                aqfc_pkg::REG_PM25_MID:  cfg_reg.pm25_mid_limit  <= cfg_wdata;
                aqfc_pkg::REG_PM25_BAD:  cfg_reg.pm25_bad_limit  <= cfg_wdata;
                aqfc_pkg::REG_PM10_GOOD: cfg_reg.pm10_good_limit <= cfg_wdata;
                aqfc_pkg::REG_PM10_MID:  cfg_reg.pm10_mid_limit  <= cfg_wdata;
                aqfc_pkg::REG_PM10_BAD:  cfg_reg.pm10_bad_limit  <= cfg_wdata;
                aqfc_pkg::REG_FAN_DELAY:
                    cfg_reg.fan_delay_seconds <= cfg_wdata[aqfc_pkg::CountWidth-1:0];
                aqfc_pkg::REG_SW_HOLD:
                    cfg_reg.switch_hold_count <= cfg_wdata[aqfc_pkg::CountWidth-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/aqfc_grade.sv
// Grades a PM2.5/PM10 reading against the three threshold pairs.
// Depends on aqfc_pkg.
`timescale 1ns / 1ps

module aqfc_grade (
    input  logic [aqfc_pkg::LimitWidth-1:0] pm25_value,
    input  logic [aqfc_pkg::LimitWidth-1:0] pm10_value,
    input  aqfc_pkg::cfg_t                  cfg,
    output aqfc_pkg::grade_t                grade
);

    logic good_ok, mid_ok, bad_ok;

    assign good_ok = (pm25_value <= cfg.pm25_good_limit) && (pm10_value <= cfg.pm10_good_limit);
    assign mid_ok  = (pm25_value <= cfg.pm25_mid_limit)  && (pm10_value <= cfg.pm10_mid_limit);
    assign bad_ok  = (pm25_value <= cfg.pm25_bad_limit)  && (pm10_value <= cfg.pm10_bad_limit);

    // First pair that holds both readings wins
    always_comb begin
        if (good_ok) begin
            grade = aqfc_pkg::GRADE_GOOD;
        end else if (mid_ok) begin
            grade = aqfc_pkg::GRADE_MID;
        end else if (bad_ok) begin
            grade = aqfc_pkg::GRADE_BAD;
        end else begin
            grade = aqfc_pkg::GRADE_ERROR;
        end
    end

endmodule

### hdl/air_quality_fan_controller.sv
// Air quality fan controller top level: event decode, mode and fan state, output word.
// The result word of an accepted word is registered in the output register.
// Throughput: one word per cycle while m_ready is high; the output register frees up in the cycle it is taken.
// Reset (aresetn low, synchronous): idle mode, fan off, grade good, LEDs off, counters
// cleared, configuration back to its defaults; no result word pending.
// Depends on aqfc_pkg, aqfc_cfg and aqfc_grade.
`timescale 1ns / 1ps

module air_quality_fan_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [aqfc_pkg::CfgAddrW-1:0]   cfg_addr,
    input  logic [aqfc_pkg::LimitWidth-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  aqfc_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output aqfc_pkg::out_word_t             m_data
);

    aqfc_pkg::cfg_t   cfg;
    aqfc_pkg::grade_t new_grade;

    logic [aqfc_pkg::CountWidth-1:0] sw1_hold_reg, sw1_hold_next;
    logic [aqfc_pkg::CountWidth-1:0] sw2_hold_reg, sw2_hold_next;
    logic [aqfc_pkg::CountWidth-1:0] on_sec_reg, on_sec_next;
    logic [aqfc_pkg::CountWidth-1:0] off_sec_reg, off_sec_next;
    logic [aqfc_pkg::MsWidth-1:0]    ms_count_reg, ms_count_next, ms_inc;
    aqfc_pkg::fan_mode_t             mode_reg, mode_next;
    aqfc_pkg::grade_t                grade_reg, grade_next;
    logic                            fan_reg, fan_next;
    logic [2:0]                      led_reg, led_next;
    logic                            heartbeat_reg, heartbeat_next;
    logic                            m_valid_reg;
    aqfc_pkg::out_word_t             m_data_reg, m_data_next;
    logic                            accept;

    aqfc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    aqfc_grade u_grade (
        .pm25_value (s_data.pm25_value),
        .pm10_value (s_data.pm10_value),
        .cfg        (cfg),
        .grade      (new_grade)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign ms_inc  = ms_count_reg + aqfc_pkg::MsWidth'(1);

    always_comb begin
        sw1_hold_next  = sw1_hold_reg;
        sw2_hold_next  = sw2_hold_reg;
        on_sec_next    = on_sec_reg;
        off_sec_next   = off_sec_reg;
        ms_count_next  = ms_count_reg;
        mode_next      = mode_reg;
        grade_next     = grade_reg;
        fan_next       = fan_reg;
        led_next       = led_reg;
        heartbeat_next = heartbeat_reg;

        case (aqfc_pkg::req_t'(s_data.req_type))
            aqfc_pkg::REQ_SWITCH: begin
                // Switch 1 wins when both are held
                if (s_data.sw1_pressed) begin
                    sw2_hold_next = '0;
                    if (sw1_hold_reg >= cfg.switch_hold_count) begin
                        mode_next = aqfc_pkg::MODE_MANUAL;
                        fan_next  = 1'b1;
                    end else begin
                        sw1_hold_next = sw1_hold_reg + aqfc_pkg::CountWidth'(1);
                    end
                end else if (s_data.sw2_pressed) begin
                    sw1_hold_next = '0;
                    if (sw2_hold_reg >= cfg.switch_hold_count) begin
                        mode_next = aqfc_pkg::MODE_AUTO;
                    end else begin
                        sw2_hold_next = sw2_hold_reg + aqfc_pkg::CountWidth'(1);
                    end
                end else begin
                    sw1_hold_next = '0;
                    sw2_hold_next = '0;
                    mode_next     = aqfc_pkg::MODE_IDLE;
                    fan_next      = 1'b0;
                end
            end
            aqfc_pkg::REQ_TICK: begin
                ms_count_next = ms_inc;
                if (ms_inc >= aqfc_pkg::TicksPerSecond) begin
                    ms_count_next  = '0;
                    heartbeat_next = !heartbeat_reg;
                    if (mode_reg != aqfc_pkg::MODE_AUTO) begin
                        on_sec_next  = '0;
                        off_sec_next = '0;
                    end else if (grade_reg == aqfc_pkg::GRADE_MID ||
                                 grade_reg == aqfc_pkg::GRADE_BAD) begin
                        off_sec_next = '0;
                        if (on_sec_reg >= cfg.fan_delay_seconds) begin
                            fan_next = 1'b1;
                        end else begin
                            on_sec_next = on_sec_reg + aqfc_pkg::CountWidth'(1);
                        end
                    end else begin
                        // Good and error grades count as clean air
                        on_sec_next = '0;
                        if (fan_reg) begin
                            if (off_sec_reg >= cfg.fan_delay_seconds) begin
                                fan_next = 1'b0;
                            end else begin
                                off_sec_next = off_sec_reg + aqfc_pkg::CountWidth'(1);
                            end
                        end else begin
                            off_sec_next = '0;
                        end
                    end
                end
            end
            aqfc_pkg::REQ_READING: begin
                grade_next = new_grade;
                led_next   = aqfc_pkg::grade_leds(new_grade);
            end
            default: ;
        endcase

        m_data_next.fan_on        = fan_next;
        m_data_next.air_grade     = grade_next;
        m_data_next.led_red       = led_next[2];
        m_data_next.led_yel       = led_next[1];
        m_data_next.led_grn       = led_next[0];
        m_data_next.fan_mode      = mode_next;
        m_data_next.heartbeat_led = heartbeat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw1_hold_reg  <= '0;
            sw2_hold_reg  <= '0;
            on_sec_reg    <= '0;
            off_sec_reg   <= '0;
            ms_count_reg  <= '0;
            mode_reg      <= aqfc_pkg::MODE_IDLE;
            grade_reg     <= aqfc_pkg::GRADE_GOOD;
            fan_reg       <= 1'b0;
            led_reg       <= '0;
            heartbeat_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                sw1_hold_reg  <= sw1_hold_next;
                sw2_hold_reg  <= sw2_hold_next;
                on_sec_reg    <= on_sec_next;
                off_sec_reg   <= off_sec_next;
                ms_count_reg  <= ms_count_next;
                mode_reg      <= mode_next;
                grade_reg     <= grade_next;
                fan_reg       <= fan_next;
                led_reg       <= led_next;
                heartbeat_reg <= heartbeat_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output word holds until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### tb/air_quality_fan_controller_tb.sv
// Self-checking testbench for air_quality_fan_controller: directed grading and switch
// cases, then randomized event traffic under several register settings.
// Depends on aqfc_pkg and the controller RTL.
`timescale 1ns / 1ps

// Tracks the controller state from accepted words and checks every status word.
class fan_status_tracker;
    localparam int MaxReports = 100;

    logic [aqfc_pkg::LimitWidth-1:0] pm25_good, pm25_mid, pm25_bad;
    logic [aqfc_pkg::LimitWidth-1:0] p10_good, p10_mid, p10_bad;
    logic [aqfc_pkg::CountWidth-1:0] fan_delay, hold_count;

    logic [aqfc_pkg::CountWidth-1:0] sw1_count, sw2_count, on_secs, off_secs;
    logic [aqfc_pkg::MsWidth-1:0]    ms_count;
    aqfc_pkg::fan_mode_t             mode;
    aqfc_pkg::grade_t                grade;
    logic [2:0]                      leds;
    logic                            fan, beat;

    aqfc_pkg::out_word_t expected_status[$];
    int                  mismatches;

    function new();
        pm25_good  = aqfc_pkg::Pm25GoodReset;
        pm25_mid   = aqfc_pkg::Pm25MidReset;
        pm25_bad   = aqfc_pkg::Pm25BadReset;
        p10_good   = aqfc_pkg::Pm10GoodReset;
        p10_mid    = aqfc_pkg::Pm10MidReset;
        p10_bad    = aqfc_pkg::Pm10BadReset;
        fan_delay  = aqfc_pkg::FanDelayReset;
        hold_count = aqfc_pkg::HoldReset;
        sw1_count  = '0;
        sw2_count  = '0;
        on_secs    = '0;
        off_secs   = '0;
        ms_count   = '0;
        mode       = aqfc_pkg::MODE_IDLE;
        grade      = aqfc_pkg::GRADE_GOOD;
        leds       = '0;
        fan        = 1'b0;
        beat       = 1'b0;
        mismatches = 0;
    endfunction

    function void write_reg(aqfc_pkg::reg_index_t idx,
                            logic [aqfc_pkg::LimitWidth-1:0] value);
        case (idx)
            aqfc_pkg::REG_PM25_GOOD: pm25_good = value;
            aqfc_pkg::REG_PM25_MID:  pm25_mid = value;
            aqfc_pkg::REG_PM25_BAD:  pm25_bad = value;
            aqfc_pkg::REG_PM10_GOOD: p10_good = value;
            aqfc_pkg::REG_PM10_MID:  p10_mid = value;
            aqfc_pkg::REG_PM10_BAD:  p10_bad = value;
            aqfc_pkg::REG_FAN_DELAY: fan_delay = value[aqfc_pkg::CountWidth-1:0];
            aqfc_pkg::REG_SW_HOLD:   hold_count = value[aqfc_pkg::CountWidth-1:0];
            default: ;
        endcase
    endfunction

    function void note_event(aqfc_pkg::in_word_t w);
        aqfc_pkg::out_word_t st;
        case (w.req_type)
            aqfc_pkg::REQ_SWITCH: begin
                // switch 1 wins when both are held
                if (w.sw1_pressed) begin
                    sw2_count = '0;
                    if (sw1_count >= hold_count) begin
                        mode = aqfc_pkg::MODE_MANUAL;
                        fan  = 1'b1;
                    end else begin
                        sw1_count = sw1_count + 1'b1;
                    end
                end else if (w.sw2_pressed) begin
                    sw1_count = '0;
                    if (sw2_count >= hold_count) begin
                        mode = aqfc_pkg::MODE_AUTO;
                    end else begin
                        sw2_count = sw2_count + 1'b1;
                    end
                end else begin
                    sw1_count = '0;
                    sw2_count = '0;
                    mode      = aqfc_pkg::MODE_IDLE;
                    fan       = 1'b0;
                end
            end
            aqfc_pkg::REQ_TICK: begin
                ms_count = ms_count + 1'b1;
                if (ms_count >= aqfc_pkg::TicksPerSecond) begin
                    ms_count = '0;
                    beat     = ~beat;
                    if (mode != aqfc_pkg::MODE_AUTO) begin
                        on_secs  = '0;
                        off_secs = '0;
                    end else if (grade == aqfc_pkg::GRADE_MID ||
                                 grade == aqfc_pkg::GRADE_BAD) begin
                        off_secs = '0;
                        if (on_secs >= fan_delay) begin
                            fan = 1'b1;
                        end else begin
                            on_secs = on_secs + 1'b1;
                        end
                    end else begin
                        // error grade falls here: treated as clean air
                        on_secs = '0;
                        if (!fan) begin
                            off_secs = '0;
                        end else if (off_secs >= fan_delay) begin
                            fan = 1'b0;
                        end else begin
                            off_secs = off_secs + 1'b1;
                        end
                    end
                end
            end
            aqfc_pkg::REQ_READING: begin
                if (w.pm25_value <= pm25_good && w.pm10_value <= p10_good) begin
                    grade = aqfc_pkg::GRADE_GOOD;
                    leds  = aqfc_pkg::LedGreen;
                end else if (w.pm25_value <= pm25_mid && w.pm10_value <= p10_mid) begin
                    grade = aqfc_pkg::GRADE_MID;
                    leds  = aqfc_pkg::LedYellow;
                end else if (w.pm25_value <= pm25_bad && w.pm10_value <= p10_bad) begin
                    grade = aqfc_pkg::GRADE_BAD;
                    leds  = aqfc_pkg::LedRed;
                end else begin
                    grade = aqfc_pkg::GRADE_ERROR;
                    leds  = aqfc_pkg::LedRed | aqfc_pkg::LedYellow | aqfc_pkg::LedGreen;
                end
            end
            default: ;
        endcase
        st.fan_on        = fan;
        st.air_grade     = grade;
        st.led_red       = leds[2];
        st.led_yel       = leds[1];
        st.led_grn       = leds[0];
        st.fan_mode      = mode;
        st.heartbeat_led = beat;
        expected_status.push_back(st);
    endfunction

    function void compare_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endfunction

    function void check_status(aqfc_pkg::out_word_t got);
        aqfc_pkg::out_word_t want;
        if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
                $display("%0t: status word expected none, got %h", $time, got);
            end
            return;
        end
        want = expected_status.pop_front();
        compare_field("fan_on", want.fan_on, got.fan_on);
        compare_field("air_grade", want.air_grade, got.air_grade);
        compare_field("led_red", want.led_red, got.led_red);
        compare_field("led_yel", want.led_yel, got.led_yel);
        compare_field("led_grn", want.led_grn, got.led_grn);
        compare_field("fan_mode", want.fan_mode, got.fan_mode);
        compare_field("heartbeat_led", want.heartbeat_led, got.heartbeat_led);
    endfunction
endclass

module air_quality_fan_controller_tb;

    localparam int         HalfPeriod = 5;
    localparam int         IdlePct    = 13;
    localparam int         RegCount   = 8;
    localparam logic [1:0] ReqUnused  = 2'd3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [aqfc_pkg::CfgAddrW-1:0]   cfg_addr  = '0;
    logic [aqfc_pkg::LimitWidth-1:0] cfg_wdata = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    aqfc_pkg::in_word_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    aqfc_pkg::out_word_t             m_data;

    logic                            gaps_on     = 1'b1;
    logic [aqfc_pkg::LimitWidth-1:0] reg_image [RegCount];
    int                              events_sent = 0;
    fan_status_tracker               tracker     = new();

    air_quality_fan_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #HalfPeriod aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= !(gaps_on && $urandom_range(99) < IdlePct);
    end

    // Note the accepted word before checking, so a same-edge pair stays in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_event(s_data);
            end
            if (m_valid && m_ready) begin
                tracker.check_status(m_data);
            end
        end
    end

    function automatic aqfc_pkg::in_word_t rand_word(input logic [1:0] req);
        aqfc_pkg::in_word_t w;
        w = $bits(aqfc_pkg::in_word_t)'({$urandom, $urandom});
        w.req_type = req;
        return w;
    endfunction

    // Pick a value on or just past a grading limit most of the time.
    function automatic logic [aqfc_pkg::LimitWidth-1:0] near_limit(
            input logic [aqfc_pkg::LimitWidth-1:0] lo, mid, hi);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return lo;
            3: return lo + 1'b1;
            4: return mid + aqfc_pkg::LimitWidth'($urandom_range(1));
            5: return hi;
            6: return hi + 1'b1;
            default: return aqfc_pkg::LimitWidth'($urandom);
        endcase
    endfunction

    task automatic send_word(input aqfc_pkg::in_word_t w);
        while (gaps_on && $urandom_range(99) < IdlePct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        events_sent++;
    endtask

    task automatic send_reading(input logic [aqfc_pkg::LimitWidth-1:0] p25, p10);
        aqfc_pkg::in_word_t w;
        w = rand_word(aqfc_pkg::REQ_READING);
        w.pm25_value = p25;
        w.pm10_value = p10;
        send_word(w);
    endtask

    task automatic send_graded_reading();
        send_reading(near_limit(tracker.pm25_good, tracker.pm25_mid, tracker.pm25_bad),
                     near_limit(tracker.p10_good, tracker.p10_mid, tracker.p10_bad));
    endtask

    task automatic send_switch(input logic s1, s2);
        aqfc_pkg::in_word_t w;
        w = rand_word(aqfc_pkg::REQ_SWITCH);
        w.sw1_pressed = s1;
        w.sw2_pressed = s2;
        send_word(w);
    endtask

    task automatic send_tick();
        send_word(rand_word(aqfc_pkg::REQ_TICK));
    endtask

    // Drop valid and hold until every status word is back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_status.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic apply_config();
        for (int i = 0; i < RegCount; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= aqfc_pkg::reg_index_t'(i);
            cfg_wdata <= reg_image[i];
            @(posedge aclk);
            tracker.write_reg(aqfc_pkg::reg_index_t'(i), reg_image[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input logic [aqfc_pkg::LimitWidth-1:0] g25, m25, b25,
                              g10, m10, b10);
        reg_image[aqfc_pkg::REG_PM25_GOOD] = g25;
        reg_image[aqfc_pkg::REG_PM25_MID]  = m25;
        reg_image[aqfc_pkg::REG_PM25_BAD]  = b25;
        reg_image[aqfc_pkg::REG_PM10_GOOD] = g10;
        reg_image[aqfc_pkg::REG_PM10_MID]  = m10;
        reg_image[aqfc_pkg::REG_PM10_BAD]  = b10;
    endtask

    // Upper byte is junk: the 8-bit registers must ignore it.
    task automatic set_counts(input logic [aqfc_pkg::CountWidth-1:0] delay, hold);
        reg_image[aqfc_pkg::REG_FAN_DELAY] = {aqfc_pkg::CountWidth'($urandom), delay};
        reg_image[aqfc_pkg::REG_SW_HOLD]   = {aqfc_pkg::CountWidth'($urandom), hold};
    endtask

    task automatic run_traffic(input int quota);
        int stop_at;
        int pick;
        int count;
        logic s1, s2;
        stop_at = events_sent + quota;
        while (events_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // hold one switch pattern; most presses last long enough to change mode
                pick = $urandom_range(99);
                s1 = (pick < 35);
                s2 = (pick >= 25 && pick < 75);
                if (!s1 && !s2) begin
                    count = $urandom_range(1, 3);
                end else if ($urandom_range(9) < 6) begin
                    count = tracker.hold_count + $urandom_range(1, 3);
                end else begin
                    count = $urandom_range(1, tracker.hold_count + 1);
                end
                repeat (count) begin
                    send_switch(s1, s2);
                    if ($urandom_range(9) == 0) begin
                        send_tick();
                    end
                end
            end else if (pick < 65) begin
                send_graded_reading();
            end else if (pick < 70) begin
                send_word(rand_word(ReqUnused));
            end else begin
                // settle on a grade, then let a few ticks pass under it
                send_graded_reading();
                count = $urandom_range(1, 8);
                repeat (count) send_tick();
            end
        end
    endtask

    initial begin : watchdog
        #10_000_000;
        $display("air_quality_fan_controller regression: fail");
        $finish;
    end

    initial begin : main
        aqfc_pkg::in_word_t              w;
        int                              quota;
        logic [aqfc_pkg::LimitWidth-1:0] a, b;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Unused code reports the reset state, LEDs still dark.
        w = '1;
        w.req_type = ReqUnused;
        send_word(w);

        // Grade boundaries at the reset limits.
        send_reading('0, '0);
        send_reading(aqfc_pkg::Pm25GoodReset, aqfc_pkg::Pm10GoodReset);
        send_reading(aqfc_pkg::Pm25GoodReset + 1'b1, aqfc_pkg::Pm10GoodReset);
        send_reading(aqfc_pkg::Pm25GoodReset, aqfc_pkg::Pm10GoodReset + 1'b1);
        send_reading(aqfc_pkg::Pm25MidReset, aqfc_pkg::Pm10MidReset);
        send_reading(aqfc_pkg::Pm25MidReset + 1'b1, '0);
        send_reading(aqfc_pkg::Pm25BadReset, aqfc_pkg::Pm10BadReset);
        send_reading(aqfc_pkg::Pm25BadReset + 1'b1, aqfc_pkg::Pm10BadReset);
        send_reading('0, aqfc_pkg::Pm10BadReset + 1'b1);
        send_reading('1, '1);
        w = '1;
        w.req_type = aqfc_pkg::REQ_TICK;
        send_word(w);

        // Zero hold count: switches act at once.
        drain();
        set_limits(aqfc_pkg::Pm25GoodReset, aqfc_pkg::Pm25MidReset, aqfc_pkg::Pm25BadReset,
                   aqfc_pkg::Pm10GoodReset, aqfc_pkg::Pm10MidReset, aqfc_pkg::Pm10BadReset);
        set_counts('0, '0);
        apply_config();
        send_switch(1'b1, 1'b1);
        send_switch(1'b0, 1'b1);
        send_switch(1'b0, 1'b0);
        send_switch(1'b0, 1'b1);
        send_switch(1'b1, 1'b0);

        // Auto mode entered from manual keeps the fan on; a clean second turns it off.
        send_switch(1'b0, 1'b1);
        send_reading('0, '0);
        repeat (aqfc_pkg::TicksPerSecond) send_tick();

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            gaps_on <= (phase != 1);
            case (phase)
                0: begin
                    set_limits(aqfc_pkg::Pm25GoodReset, aqfc_pkg::Pm25MidReset,
                               aqfc_pkg::Pm25BadReset, aqfc_pkg::Pm10GoodReset,
                               aqfc_pkg::Pm10MidReset, aqfc_pkg::Pm10BadReset);
                    set_counts(aqfc_pkg::FanDelayReset, aqfc_pkg::HoldReset);
                    quota = 120;
                end
                1: begin
                    set_limits(16'd10, 16'd20, 16'd30, 16'd20, 16'd40, 16'd60);
                    set_counts('0, '0);
                    quota = 150;
                end
                2: begin
                    set_limits('0, '0, '0, '0, '0, '0);
                    set_counts(8'd1, 8'd1);
                    quota = 150;
                end
                3: begin
                    set_limits('1, '1, '1, '1, '1, '1);
                    set_counts('1, '1);
                    quota = 100;
                end
                4: begin
                    a = aqfc_pkg::LimitWidth'($urandom_range(0, 200));
                    b = a + aqfc_pkg::LimitWidth'($urandom_range(0, 200));
                    set_limits(a, b, b + aqfc_pkg::LimitWidth'($urandom_range(0, 200)),
                               a + 1'b1, b + 1'b1,
                               b + aqfc_pkg::LimitWidth'($urandom_range(1, 400)));
                    set_counts(8'd2, 8'd3);
                    quota = 150;
                end
                default: begin
                    set_limits(aqfc_pkg::LimitWidth'($urandom),
                               aqfc_pkg::LimitWidth'($urandom),
                               aqfc_pkg::LimitWidth'($urandom),
                               aqfc_pkg::LimitWidth'($urandom),
                               aqfc_pkg::LimitWidth'($urandom),
                               aqfc_pkg::LimitWidth'($urandom));
                    set_counts(aqfc_pkg::CountWidth'($urandom_range(0, 3)),
                               aqfc_pkg::CountWidth'($urandom_range(0, 8)));
                    quota = 150;
                end
            endcase
            apply_config();
            run_traffic(quota);
        end

        drain();
        if (tracker.mismatches == 0) begin
            $display("air_quality_fan_controller regression: pass");
        end else begin
            $display("air_quality_fan_controller regression: fail");
        end
        $finish;
    end

endmodule
